[sv/euler_cycle_finder_assert.svh]
// ----------------------------------------------------------------------------
// Euler cycle finder assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EULER_CYCLE_FINDER_ASSERT_SVH
`define EULER_CYCLE_FINDER_ASSERT_SVH

`ifndef SYNTHESIS
`define ECF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ECF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ECF_ASSERT_IMP(label, ante, cons, msg)
`define ECF_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[sv/ecf_pkg.sv]
// ----------------------------------------------------------------------------
// Euler cycle finder package
// Shared widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ecf_pkg;

  localparam int VERTEX_W  = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_VERTICES = 8;
  localparam int DEF_STACK_DEPTH  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b1;

  localparam logic [CFG_W-1:0]    RESET_NUM_VERTICES = 4'd8;
  localparam logic [VERTEX_W-1:0] RESET_START_VERTEX = 3'd0;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_RUN      = 1'b1;

  localparam logic STATUS_CYCLE      = 1'b0;
  localparam logic STATUS_NOT_EULER  = 1'b1;

  typedef struct packed {
    logic add_edge;
    logic fail;
    logic walk_init;
    logic push_nb;
    logic pop;
    logic load_top;
    logic restart;
    logic flush;
  } ecf_cmd_t;

  typedef struct packed {
    logic odd_found;
    logic has_nb;
    logic any_edge;
    logic depth_one;
    logic out_free;
    logic can_emit;
    logic pend_valid;
  } ecf_stat_t;

endpackage

[sv/ecf_in_if.sv]
// ----------------------------------------------------------------------------
// Euler cycle finder input channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface ecf_in_if;
  import ecf_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;

  modport source (output valid, cmd, vertex_a, vertex_b, input ready);
  modport sink   (input valid, cmd, vertex_a, vertex_b, output ready);
endinterface

[sv/ecf_out_if.sv]
// ----------------------------------------------------------------------------
// Euler cycle finder result channel
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface ecf_out_if;
  import ecf_pkg::*;

  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex;
  logic                status;
  logic                cycle_start;
  logic                last;

  modport source (output valid, vertex, status, cycle_start, last, input ready);
  modport sink   (input valid, vertex, status, cycle_start, last, output ready);
endinterface

[sv/ecf_ctrl.sv]
// ----------------------------------------------------------------------------
// Euler cycle finder controller
// State machine sequencing degree check, stack walk, restarts and flush.
// ----------------------------------------------------------------------------
module ecf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  ecf_pkg::ecf_stat_t stat,
  output logic              in_ready,
  output ecf_pkg::ecf_cmd_t cmd
);
  import ecf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_STEP    = 6'b000100,
    S_LOAD    = 6'b001000,
    S_RESTART = 6'b010000,
    S_FLUSH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_RUN) begin
            state_nxt = S_CHECK;
          end else begin
            cmd.add_edge = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (stat.odd_found) begin
          if (stat.out_free) begin
            cmd.fail  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.has_nb) begin
          cmd.push_nb = 1'b1;
        end else if (stat.can_emit) begin
          cmd.pop   = 1'b1;
          state_nxt = stat.depth_one ? S_RESTART : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_top = 1'b1;
        state_nxt    = S_STEP;
      end
      S_RESTART: begin
        if (stat.any_edge) begin
          cmd.restart = 1'b1;
          state_nxt   = S_STEP;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/ecf_dpath.sv]
// ----------------------------------------------------------------------------
// Euler cycle finder datapath
// Adjacency matrix, walk stack memory, pending result and output register.
// ----------------------------------------------------------------------------
module ecf_dpath #(
  parameter int MAX_VERTICES = ecf_pkg::DEF_MAX_VERTICES,
  parameter int STACK_DEPTH  = ecf_pkg::DEF_STACK_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ecf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecf_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic [ecf_pkg::VERTEX_W-1:0]   in_vertex_a,
  input  logic [ecf_pkg::VERTEX_W-1:0]   in_vertex_b,
  input  ecf_pkg::ecf_cmd_t              cmd,
  output ecf_pkg::ecf_stat_t             stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ecf_pkg::VERTEX_W-1:0]   out_vertex,
  output logic                           out_status,
  output logic                           out_cycle_start,
  output logic                           out_last
);
  import ecf_pkg::*;

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [MAX_VERTICES-1:0] rows_r   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rows_nxt [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_m    [MAX_VERTICES];
  logic [VERTEX_W-1:0]     stack_mem [STACK_DEPTH];

  logic [CFG_W-1:0]    num_r;
  logic [VERTEX_W-1:0] start_r;
  logic [DW-1:0]       depth_r;
  logic [VERTEX_W-1:0] top_r;
  logic                first_r;
  logic                pend_valid_r;
  logic [VERTEX_W-1:0] pend_vertex_r;
  logic                pend_first_r;
  logic                out_valid_r;
  logic [VERTEX_W-1:0] out_vertex_r;
  logic                out_status_r;
  logic                out_cs_r;
  logic                out_last_r;
  logic [VERTEX_W-1:0] rd_data_r;

  logic [CFG_W-1:0]        n_act;
  logic [MAX_VERTICES-1:0] mask;
  logic [MAX_VERTICES-1:0] odd;
  logic [MAX_VERTICES-1:0] nz;
  logic [MAX_VERTICES-1:0] nb;
  logic [VERTEX_W-1:0]     odd_v;
  logic [VERTEX_W-1:0]     min_v;
  logic [VERTEX_W-1:0]     nb_v;
  logic                    top_in;
  logic                    out_free;
  logic                    push_en;
  logic [VERTEX_W-1:0]     push_v;
  logic [DW-1:0]           base_depth;
  logic                    push_ok;
  logic [AW-1:0]           rd_addr;
  logic                    edge_ok;
  logic                    load_out;

  always_comb begin
    n_act = (num_r > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : num_r;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i]  = (CFG_W'(i) < n_act);
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      row_m[i] = rows_r[i] & mask;
      odd[i]   = mask[i] & (^row_m[i]);
      nz[i]    = mask[i] & (|row_m[i]);
    end
    odd_v = '0;
    min_v = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (odd[i]) odd_v = VERTEX_W'(i);
      if (nz[i])  min_v = VERTEX_W'(i);
    end
    top_in = ({1'b0, top_r} < n_act);
    nb     = top_in ? row_m[top_r[IW-1:0]] : '0;
    nb_v   = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (nb[i]) nb_v = VERTEX_W'(i);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.odd_found  = |odd;
    stat.has_nb     = |nb;
    stat.any_edge   = |nz;
    stat.depth_one  = (depth_r == DW'(1));
    stat.out_free   = out_free;
    stat.can_emit   = !pend_valid_r || out_free;
    stat.pend_valid = pend_valid_r;
  end

  assign edge_ok = (in_vertex_a != in_vertex_b)
                && ({1'b0, in_vertex_a} < (VERTEX_W + 1)'(MAX_VERTICES))
                && ({1'b0, in_vertex_b} < (VERTEX_W + 1)'(MAX_VERTICES));

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      rows_nxt[i] = rows_r[i];
    end
    if (cmd.add_edge && edge_ok) begin
      rows_nxt[in_vertex_a[IW-1:0]][in_vertex_b[IW-1:0]] = 1'b1;
      rows_nxt[in_vertex_b[IW-1:0]][in_vertex_a[IW-1:0]] = 1'b1;
    end
    if (cmd.push_nb) begin
      rows_nxt[top_r[IW-1:0]][nb_v[IW-1:0]] = 1'b0;
      rows_nxt[nb_v[IW-1:0]][top_r[IW-1:0]] = 1'b0;
    end
    if (cmd.fail || cmd.flush) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows_nxt[i] = '0;
      end
    end
  end

  assign push_en    = cmd.push_nb | cmd.walk_init | cmd.restart;
  assign push_v     = cmd.walk_init ? start_r : (cmd.restart ? min_v : nb_v);
  assign base_depth = cmd.walk_init ? '0 : depth_r;
  assign push_ok    = push_en && (base_depth < DW'(STACK_DEPTH));
  assign rd_addr    = AW'(depth_r - DW'(2));
  assign load_out   = cmd.fail | cmd.flush | (cmd.pop & pend_valid_r);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      stack_mem[base_depth[AW-1:0]] <= push_v;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows_r[i] <= '0;
      end
      num_r        <= RESET_NUM_VERTICES;
      start_r      <= RESET_START_VERTEX;
      depth_r      <= '0;
      first_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        rows_r[i] <= rows_nxt[i];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_VERTICES: num_r   <= cfg_wdata;
          CFG_START_VERTEX: start_r <= cfg_wdata[VERTEX_W-1:0];
          default: ;
        endcase
      end
      if (push_ok) begin
        depth_r <= base_depth + DW'(1);
      end else if (cmd.walk_init) begin
        depth_r <= '0;
      end else if (cmd.pop) begin
        depth_r <= depth_r - DW'(1);
      end else if (cmd.fail || cmd.flush) begin
        depth_r <= '0;
      end
      if (cmd.walk_init || cmd.restart) begin
        first_r <= 1'b1;
      end else if (cmd.pop) begin
        first_r <= 1'b0;
      end
      if (cmd.pop) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      top_r <= push_v;
    end else if (cmd.load_top) begin
      top_r <= rd_data_r;
    end
    if (cmd.pop) begin
      pend_vertex_r <= top_r;
      pend_first_r  <= first_r;
    end
    if (cmd.fail) begin
      out_vertex_r <= odd_v;
      out_status_r <= STATUS_NOT_EULER;
      out_cs_r     <= 1'b0;
      out_last_r   <= 1'b1;
    end else if (load_out) begin
      out_vertex_r <= pend_vertex_r;
      out_status_r <= STATUS_CYCLE;
      out_cs_r     <= pend_first_r;
      out_last_r   <= cmd.flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vertex      = out_vertex_r;
  assign out_status      = out_status_r;
  assign out_cycle_start = out_cs_r;
  assign out_last        = out_last_r;

endmodule

[sv/euler_cycle_finder.sv]
// ----------------------------------------------------------------------------
// Euler cycle finder
// Hierholzer walk over an adjacency bit matrix, one vertex per result.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        cmd, vertex_a, vertex_b
//   out_ch   out  valid/ready        vertex, status, cycle_start, last
//   cfg      in   cfg_we             cfg_index, cfg_wdata
//
// An add-edge transaction is taken in S_IDLE. Run: a degree check, then a
// push per edge, a pop per vertex followed by a stack memory read (S_LOAD)
// or a restart check, a restart per further pass and one flush at the end.
// Output stalls hold the walk at a pop while a result is waiting, and hold
// the not-Eulerian or final result until the output register frees.
// Reset clears the matrix; no clearing pass.
// ----------------------------------------------------------------------------
`include "euler_cycle_finder_assert.svh"

module euler_cycle_finder #(
  parameter int MAX_VERTICES = ecf_pkg::DEF_MAX_VERTICES,
  parameter int STACK_DEPTH  = ecf_pkg::DEF_STACK_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ecf_in_if.sink                        in_ch,
  ecf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ecf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecf_pkg::CFG_W-1:0]     cfg_wdata
);
  import ecf_pkg::*;

  ecf_cmd_t  cmd;
  ecf_stat_t stat;
  logic      run_accept;
  logic      fail_seen;

  ecf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  ecf_dpath #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_vertex_a     (in_ch.vertex_a),
    .in_vertex_b     (in_ch.vertex_b),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_vertex      (out_ch.vertex),
    .out_status      (out_ch.status),
    .out_cycle_start (out_ch.cycle_start),
    .out_last        (out_ch.last)
  );

  assign run_accept = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_RUN);
  assign fail_seen  = out_ch.valid && out_ch.last && (out_ch.status == STATUS_NOT_EULER);

  `ECF_ASSERT_IMP(a_idle_no_pending, in_ch.ready, !stat.pend_valid, "pending result while idle")
  `ECF_ASSERT_NEXT(a_run_busy, run_accept, !in_ch.ready, "ready right after run transaction")
  `ECF_ASSERT_NEXT(a_fail_last, cmd.fail, fail_seen, "not-Eulerian result missing")

endmodule

[test/ecf_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The channel interfaces come from the design sources; only the result struct is added here.
// ----------------------------------------------------------------------------
package ecf_tb_pkg;
  import ecf_pkg::*;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                status;
    logic                cycle_start;
    logic                last;
  } euler_result_t;
endpackage

[test/ecf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler cycle checker
// Watches both channels, walks its own copy of the graph on each run
// transaction and compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module ecf_checker
  import ecf_pkg::*;
  import ecf_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ecf_in_if.sink               in_mon,
  ecf_out_if.sink              out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending_count,
  output int                   result_count
);
  logic [7:0]          adj_rows [8];
  logic [CFG_W-1:0]    vert_count;
  logic [VERTEX_W-1:0] walk_origin;
  euler_result_t       cycle_queue [$];

  assign pending_count = cycle_queue.size();

  function automatic int high_neighbour(logic [7:0] bits);
    for (int w = 7; w >= 0; w--) if (bits[w]) return w;
    return -1;
  endfunction

  task automatic predict_run();
    int n, w, depth, v, cnt, base;
    logic [7:0] mask;
    logic [2:0] stk [32];
    logic [2:0] top;
    logic [7:0] nb;
    logic first;
    euler_result_t r;
    n = (vert_count > 8) ? 8 : vert_count;
    mask = 8'((9'd1 << n) - 1);
    for (v = 0; v < n; v++) begin
      if ($countones(adj_rows[v] & mask) % 2 == 1) begin
        r = '{vertex: v[2:0], status: STATUS_NOT_EULER, cycle_start: 1'b0, last: 1'b1};
        cycle_queue.push_back(r);
        for (int i = 0; i < 8; i++) adj_rows[i] = '0;
        return;
      end
    end
    base = cycle_queue.size();
    cnt = 0;
    depth = 1;
    stk[0] = walk_origin;
    first = 1'b1;
    forever begin
      while (depth > 0) begin
        top = stk[depth-1];
        nb = (top < n) ? (adj_rows[top] & mask) : 8'h00;
        w = high_neighbour(nb);
        if (w >= 0) begin
          adj_rows[top][w] = 1'b0;
          adj_rows[w][top] = 1'b0;
          if (depth < 32) begin
            stk[depth] = w[2:0];
            depth++;
          end
        end else begin
          depth--;
          if (cnt < 40) begin
            r = '{vertex: top, status: STATUS_CYCLE, cycle_start: first, last: 1'b0};
            cycle_queue.push_back(r);
            cnt++;
          end
          first = 1'b0;
        end
      end
      for (v = 0; v < n; v++) if ((adj_rows[v] & mask) != 0) break;
      if (v >= n) break;
      stk[0] = v[2:0];
      depth = 1;
      first = 1'b1;
    end
    if (cnt > 0) cycle_queue[base+cnt-1].last = 1'b1;
    for (int i = 0; i < 8; i++) adj_rows[i] = '0;
  endtask

  always @(posedge clk) begin
    euler_result_t got, exp_r;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) adj_rows[i] = '0;
      vert_count = RESET_NUM_VERTICES;
      walk_origin = RESET_START_VERTEX;
      cycle_queue.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_VERTICES) vert_count = cfg_wdata;
        else walk_origin = cfg_wdata[VERTEX_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.vertex, out_mon.status, out_mon.cycle_start, out_mon.last};
        result_count++;
        if (cycle_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          exp_r = cycle_queue.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected v=%0d s=%0d c=%0d l=%0d actual v=%0d s=%0d c=%0d l=%0d",
                     $time, exp_r.vertex, exp_r.status, exp_r.cycle_start, exp_r.last,
                     got.vertex, got.status, got.cycle_start, got.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.cmd == CMD_RUN) predict_run();
        else if (in_mon.vertex_a != in_mon.vertex_b) begin
          adj_rows[in_mon.vertex_a][in_mon.vertex_b] = 1'b1;
          adj_rows[in_mon.vertex_b][in_mon.vertex_a] = 1'b1;
        end
      end
    end
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler cycle finder testbench
// Builds graphs edge by edge, runs the circuit search under several vertex
// counts and start vertices with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import ecf_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NUM_VERTICES;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int fail_count, pending_count, result_count;
  int run_count = 0;
  int sent_count = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  ecf_in_if in_ch ();
  ecf_out_if out_ch ();

  euler_cycle_finder uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ecf_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD_EDGE;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : sink_side
    int gap;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send(logic c, logic [2:0] a, logic [2:0] b, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.vertex_a <= a;
    in_ch.vertex_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    if (c == CMD_RUN) run_count++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_graph(int n, bit gaps);
    int ne;
    logic [2:0] p, q;
    ne = $urandom_range(1, 10);
    for (int i = 0; i < ne; i++) begin
      p = 3'($urandom_range(0, n - 1));
      q = 3'($urandom_range(0, n - 1));
      send(CMD_ADD_EDGE, p, q, gaps);
    end
  endtask

  task automatic cycle_graph(int n);
    int len;
    logic [2:0] vs [8];
    len = $urandom_range(3, n < 3 ? 3 : n);
    for (int i = 0; i < len; i++) vs[i] = 3'($urandom_range(0, 7));
    for (int i = 0; i < len; i++) send(CMD_ADD_EDGE, vs[i], vs[(i + 1) % len], 1'b1);
  endtask

  initial begin : stim
    int nv;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    send(CMD_RUN, 3'd0, 3'd0, 1'b0);
    send(CMD_ADD_EDGE, 3'd0, 3'd7, 1'b0);
    send(CMD_ADD_EDGE, 3'd7, 3'd0, 1'b0);
    send(CMD_ADD_EDGE, 3'd3, 3'd3, 1'b0);
    send(CMD_RUN, 3'd7, 3'd7, 1'b0);
    send(CMD_ADD_EDGE, 3'd0, 3'd1, 1'b0);
    send(CMD_ADD_EDGE, 3'd1, 3'd2, 1'b0);
    send(CMD_ADD_EDGE, 3'd2, 3'd0, 1'b0);
    send(CMD_ADD_EDGE, 3'd5, 3'd6, 1'b0);
    send(CMD_ADD_EDGE, 3'd6, 3'd7, 1'b0);
    send(CMD_ADD_EDGE, 3'd7, 3'd5, 1'b0);
    send(CMD_RUN, 3'd0, 3'd0, 1'b0);
    write_cfg(CFG_NUM_VERTICES, 4'd4);
    write_cfg(CFG_START_VERTEX, 4'd6);
    send(CMD_ADD_EDGE, 3'd1, 3'd2, 1'b0);
    send(CMD_ADD_EDGE, 3'd2, 3'd3, 1'b0);
    send(CMD_ADD_EDGE, 3'd3, 3'd1, 1'b0);
    send(CMD_ADD_EDGE, 3'd5, 3'd6, 1'b0);
    send(CMD_RUN, 3'd0, 3'd0, 1'b0);
    write_cfg(CFG_NUM_VERTICES, 4'd15);
    write_cfg(CFG_START_VERTEX, 4'd7);
    send(CMD_ADD_EDGE, 3'd7, 3'd3, 1'b0);
    send(CMD_RUN, 3'd0, 3'd0, 1'b0);
    write_cfg(CFG_NUM_VERTICES, 4'd0);
    send(CMD_ADD_EDGE, 3'd1, 3'd2, 1'b0);
    send(CMD_RUN, 3'd0, 3'd0, 1'b0);
    write_cfg(CFG_NUM_VERTICES, 4'd1);
    send(CMD_RUN, 3'd0, 3'd0, 1'b0);

    while (sent_count < 110) begin
      if ($urandom_range(0, 2) == 0) begin
        nv = $urandom_range(0, 15);
        write_cfg(CFG_NUM_VERTICES, nv[CFG_W-1:0]);
        write_cfg(CFG_START_VERTEX, 4'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 4) == 0) random_graph(8, 1'b1);
      else begin
        repeat ($urandom_range(1, 3)) cycle_graph(8);
        if ($urandom_range(0, 5) == 0) send(CMD_ADD_EDGE, 3'($urandom), 3'($urandom), 1'b1);
      end
      if (!hold_done && sent_count > 60) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      send(CMD_RUN, 3'($urandom), 3'($urandom), 1'b1);
      if ($urandom_range(0, 6) == 0) drain();
    end
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d run transactions and %0d result transactions.",
             run_count, result_count);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/ecf_pkg.sv
sv/ecf_in_if.sv
sv/ecf_out_if.sv
sv/ecf_ctrl.sv
sv/ecf_dpath.sv
sv/euler_cycle_finder.sv
test/ecf_tb_if.sv
test/ecf_checker.sv
test/tb_top.sv
